// ===== rtl/sfe_pkg.sv =====
// Shared constants and types for the symmetric FIR with edge clamping.
`timescale 1ns / 1ps
package sfe_pkg;

  // Coefficient format: signed Q1.15, two coefficients per 32-bit register.
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 8;

  // Per-cycle control that the top level broadcasts to every tap cell.
  typedef struct packed {
    logic shift;    // move the delay line one place
    logic load;     // fill the whole delay line with the first sample of a block
    logic prod_en;  // capture the tap product of the current window
  } sfe_cell_ctl_t;

endpackage

// ===== rtl/symmetric_fir_edge_clamp.sv =====
// Top level of the symmetric FIR block filter with clamped block edges.
// A result passes the window stage, the product stage, the adder tree levels and the output
// register, and results lag the samples by HALF_TAPS-1 samples.
// Throughput: one sample per cycle unless the output stalls; after a last beat the input
// holds off for HALF_TAPS-1 flush steps, one per unstalled cycle, shifting out the windows.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the block state and
// returns the coefficient registers to a pass-through: centre tap 32767, all others 0.
`timescale 1ns / 1ps
module symmetric_fir_edge_clamp import sfe_pkg::*; #(
  parameter int HALF_TAPS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  // Filtered output channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last,
  // Coefficient register write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // Register file geometry: two coefficients per register.
  localparam int NUM_REGS = (HALF_TAPS + 1) / 2;
  localparam int REG_IW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  // Counters hold values up to HALF_TAPS.
  localparam int CNT_W    = $clog2(HALF_TAPS + 1);
  // Adder tree over the tap products, padded to a power of two.
  localparam int LVLS     = $clog2(HALF_TAPS);
  localparam int LEAVES   = 1 << LVLS;
  localparam int PROD_W   = SAMPLE_BITS + COEF_W + 1;
  localparam int ACC_W    = PROD_W + LVLS;
  localparam int QW       = ACC_W - COEF_FRAC;
  // Pipeline stages: window, products, LVLS tree levels, output register.
  localparam int NS       = LVLS + 3;
  localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-(2 ** (SAMPLE_BITS - 1)));
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HALF_TAPS);
  localparam logic [CNT_W-1:0] FLUSH_CNT = CNT_W'(HALF_TAPS - 1);

  // ---------------------------------------------------------------------------
  // Coefficient registers. Writes beyond the register list are dropped.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] taps_r [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        taps_r[i] <= '0;
      end
      taps_r[0] <= CFG_DATA_W'(32767);
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      taps_r[cfg_index[REG_IW-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Each stage takes a new beat when it is empty or when
  // the stage after it moves on, so bubbles close up; a result waiting in the
  // output register stops the stages in front of it once each of them holds a beat.
  // ---------------------------------------------------------------------------
  logic v_r    [NS];
  logic last_r [NS];
  logic rdy    [NS+1];

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  // ---------------------------------------------------------------------------
  // Block control. fill_r counts the samples of the current block up to
  // HALF_TAPS. A last beat starts HALF_TAPS-1 flush steps that keep shifting
  // the last sample in, which gives the clamp on the right edge. A flush step
  // emits a window only for the final keep_r steps of the flush.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] keep_r, keep_nxt;
  logic             in_beat;
  logic             flushing;
  logic             flush_step;
  logic             win_emit;
  logic             win_last;
  sfe_cell_ctl_t    ctl;

  logic signed [SAMPLE_BITS-1:0] left_q  [HALF_TAPS];
  logic signed [SAMPLE_BITS-1:0] right_q [HALF_TAPS];
  logic signed [SAMPLE_BITS-1:0] shift_data;

  assign flushing   = (rem_r != '0);
  assign in_ready   = rdy[0] && !flushing;
  assign in_beat    = in_valid && in_ready;
  assign flush_step = flushing && rdy[0];
  assign fill_inc   = (fill_r == FULL_CNT) ? fill_r : fill_r + CNT_W'(1);

  // The newest sample sits in the left register of the last cell; a flush
  // step shifts it in again.
  assign shift_data = flushing ? left_q[HALF_TAPS-1] : in_sample;

  assign ctl.load    = in_beat && (fill_r == '0);
  assign ctl.shift   = (in_beat && (fill_r != '0)) || flush_step;
  assign ctl.prod_en = rdy[1] && v_r[0];

  always_comb begin
    fill_nxt = fill_r;
    rem_nxt  = rem_r;
    keep_nxt = keep_r;
    win_emit = 1'b0;
    win_last = 1'b0;
    if (in_beat) begin
      win_emit = (fill_inc == FULL_CNT);
      if (in_last) begin
        fill_nxt = '0;
        rem_nxt  = FLUSH_CNT;
        keep_nxt = fill_inc;
      end else begin
        fill_nxt = fill_inc;
      end
    end else if (flush_step) begin
      win_emit = (rem_r <= keep_r);
      win_last = (rem_r == CNT_W'(1));
      rem_nxt  = rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rem_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    keep_r <= keep_nxt;
  end

  // ---------------------------------------------------------------------------
  // Row of tap cells. Cell t holds delay-line places HALF_TAPS-1-t (left) and
  // HALF_TAPS-1+t (right). Left samples move from the last cell toward the
  // centre, right samples from the centre outward, one place per step. The
  // window marked valid in stage 0 is simply the contents of the row.
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef   [HALF_TAPS];
  logic signed [PROD_W-1:0] prod_q [HALF_TAPS];

  generate
    for (genvar t = 0; t < HALF_TAPS; t++) begin : g_cell
      localparam int REG_SEL  = t >> 1;
      localparam int HALF_SEL = t & 1;
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;

      assign coef[t] = taps_r[REG_SEL][HALF_SEL*COEF_W +: COEF_W];

      if (t == HALF_TAPS - 1) begin : g_newest
        assign left_in = shift_data;
      end else begin : g_inner
        assign left_in = left_q[t+1];
      end

      if (t == 0) begin : g_mid
        assign right_in = '0;
      end else begin : g_side
        assign right_in = right_q[t-1];
      end

      sfe_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CENTER      (t == 0)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .load_sample (in_sample),
        .left_in     (left_in),
        .right_in    (right_in),
        .coef        (coef[t]),
        .left_q      (left_q[t]),
        .right_q     (right_q[t]),
        .prod_q      (prod_q[t])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Registered adder tree, heap ordered: node 1 is the root, node k adds
  // nodes 2k and 2k+1, and the leaves are the cell products padded with zero.
  // Tree depth d is pipeline stage 2 + (LVLS-1-d).
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] leaf   [LEAVES];
  logic signed [ACC_W-1:0] node_r [1:LEAVES-1];

  generate
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < HALF_TAPS) begin : g_prod
        assign leaf[k] = ACC_W'(prod_q[k]);
      end else begin : g_pad
        assign leaf[k] = '0;
      end
    end

    for (genvar k = 1; k < LEAVES; k++) begin : g_node
      localparam int DEPTH = $clog2(k + 1) - 1;
      localparam int STG   = 2 + (LVLS - 1 - DEPTH);
      logic signed [ACC_W-1:0] lhs;
      logic signed [ACC_W-1:0] rhs;

      if (2 * k >= LEAVES) begin : g_from_leaf
        assign lhs = leaf[2*k-LEAVES];
        assign rhs = leaf[2*k+1-LEAVES];
      end else begin : g_from_node
        assign lhs = node_r[2*k];
        assign rhs = node_r[2*k+1];
      end

      always_ff @(posedge clk) begin
        if (rdy[STG] && v_r[STG-1]) begin
          node_r[k] <= lhs + rhs;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Output stage: truncate the Q15 sum toward zero, then saturate.
  // A negative sum gets 2^15-1 added before the arithmetic shift.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]       rounded;
  logic signed [QW-1:0]          quot;
  logic signed [SAMPLE_BITS-1:0] sat_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  assign rounded = node_r[1] + $signed({{(ACC_W-COEF_FRAC){1'b0}},
                                        {COEF_FRAC{node_r[1][ACC_W-1]}}});
  assign quot    = rounded[ACC_W-1:COEF_FRAC];

  always_comb begin
    if (quot > Q_MAX) begin
      sat_nxt = Q_MAX[SAMPLE_BITS-1:0];
    end else if (quot < Q_MIN) begin
      sat_nxt = Q_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_nxt = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1] && v_r[NS-2]) begin
      out_sample_r <= sat_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid and last flags.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= win_emit;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      last_r[0] <= win_last;
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_last   = last_r[NS-1];
  assign out_sample = out_sample_r;

endmodule

// ===== rtl/sfe_cell.sv =====
// One tap cell: a folded pair of delay-line samples, pre-adder and product register.
`timescale 1ns / 1ps
module sfe_cell import sfe_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter bit CENTER      = 1'b0
) (
  input  logic                                clk,
  input  sfe_cell_ctl_t                       ctl,
  input  logic signed [SAMPLE_BITS-1:0]       load_sample,
  input  logic signed [SAMPLE_BITS-1:0]       left_in,
  input  logic signed [SAMPLE_BITS-1:0]       right_in,
  input  logic signed [COEF_W-1:0]            coef,
  output logic signed [SAMPLE_BITS-1:0]       left_q,
  output logic signed [SAMPLE_BITS-1:0]       right_q,
  output logic signed [SAMPLE_BITS+COEF_W:0]  prod_q
);

  logic signed [SAMPLE_BITS-1:0]      left_r;
  logic signed [SAMPLE_BITS:0]        preadd;
  logic signed [SAMPLE_BITS+COEF_W:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      left_r <= load_sample;
    end else if (ctl.shift) begin
      left_r <= left_in;
    end
  end

  generate
    if (CENTER) begin : g_center
      // The centre tap is used once; its sample also feeds the right half.
      assign right_q = left_r;
      assign preadd  = (SAMPLE_BITS+1)'(left_r);
    end else begin : g_pair
      logic signed [SAMPLE_BITS-1:0] right_r;

      always_ff @(posedge clk) begin
        if (ctl.load) begin
          right_r <= load_sample;
        end else if (ctl.shift) begin
          right_r <= right_in;
        end
      end

      assign right_q = right_r;
      assign preadd  = (SAMPLE_BITS+1)'(left_r) + (SAMPLE_BITS+1)'(right_r);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= preadd * coef;
    end
  end

  assign left_q = left_r;
  assign prod_q = prod_r;

endmodule

// ===== rtl/sfe_checker.sv =====
// Port-level checks for the symmetric FIR with edge clamping, and their binding.
`timescale 1ns / 1ps
module sfe_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_last
);

  // A stalled output beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("output beat changed while stalled");

  // A last input beat starts the flush, so the next cycle takes no sample.
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted right after a last beat");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind symmetric_fir_edge_clamp sfe_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_last    (in_last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_last   (out_last)
);

// ===== bench/symmetric_fir_edge_clamp_tb.sv =====
// Self-checking testbench for the symmetric FIR block filter with clamped block edges.
`timescale 1ns / 1ps
module symmetric_fir_edge_clamp_tb import sfe_pkg::*; ();

  localparam int HALF_TAPS    = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int LINE_LEN     = 2 * HALF_TAPS - 1;
  localparam int NUM_TAP_REGS = (HALF_TAPS + 1) / 2;

  // A result leaves through the pipeline registers after the step that forms its window;
  // SETTLE_CYCLES quiet cycles after the last result guarantee that the pipeline is empty.
  localparam int PIPE_LATENCY  = 2 + $clog2(HALF_TAPS);
  localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
  localparam int RESET_CYCLES  = 7;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_SAMPLES = 15;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 40;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [CFG_DATA_W-1:0] TAPS_0_1_RESET = 32'd32767;
  localparam logic [CFG_DATA_W-1:0] TAPS_ALL_MAX   = 32'h7FFF_7FFF;
  localparam logic [CFG_DATA_W-1:0] TAPS_ALL_MIN   = 32'h8000_8000;

  // Coefficient register map, plus an index that decodes to no register at all.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPS_0_1     = 8'd0,
    REG_TAPS_2_3     = 8'd1,
    REG_TAPS_4_5     = 8'd2,
    REG_TAPS_6_7     = 8'd3,
    REG_TAPS_8_9     = 8'd4,
    REG_TAPS_10_11   = 8'd5,
    REG_TAPS_12_13   = 8'd6,
    REG_TAPS_14_15   = 8'd7,
    REG_OUT_OF_RANGE = 8'hFF
  } tap_reg_t;

  // One beat on either sample channel.
  typedef struct packed {
    logic                          last;
    logic signed [SAMPLE_BITS-1:0] sample;
  } audio_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          in_last = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  symmetric_fir_edge_clamp #(
    .HALF_TAPS  (HALF_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Samples waiting to be offered, and filtered samples that the block still owes.
  audio_beat_t pending_beats[$];
  audio_beat_t expected_samples[$];

  // Idle rates in percent, set per phase by the stimulus sequence.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // A long receiver hold is asked for by bumping holds_asked.
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // Handshake flags captured at every rising edge.
  bit in_beat = 1'b0;
  bit cfg_beat = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned samples_taken = 0;
  int unsigned samples_checked = 0;
  int unsigned blocks_queued = 0;
  int unsigned cfg_writes = 0;

  // Predicted filter state: the delay line (newest first), the number of samples
  // taken in the current block (saturating at HALF_TAPS), and the coefficient words.
  logic signed [SAMPLE_BITS-1:0] fir_line [LINE_LEN];
  int unsigned                   block_fill;
  logic [CFG_DATA_W-1:0]         tap_words [NUM_TAP_REGS];

  function automatic longint tap_coef(int t);
    logic [CFG_DATA_W-1:0] w;
    w = tap_words[t / 2];
    if (t % 2)
      return longint'($signed(w[2*COEF_W-1:COEF_W]));
    return longint'($signed(w[COEF_W-1:0]));
  endfunction

  // The window is symmetric around its middle entry, so each pair of mirrored
  // samples shares one coefficient. The Q15 sum is cut toward zero, then saturated.
  function automatic logic signed [SAMPLE_BITS-1:0] window_output();
    longint acc;
    longint y;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    acc = tap_coef(0) * longint'(fir_line[HALF_TAPS-1]);
    for (int t = 1; t < HALF_TAPS; t++)
      acc += tap_coef(t) *
             (longint'(fir_line[HALF_TAPS-1-t]) + longint'(fir_line[HALF_TAPS-1+t]));
    if (acc < 0)
      y = -((-acc) >>> COEF_FRAC);
    else
      y = acc >>> COEF_FRAC;
    if (y > hi)
      y = hi;
    if (y < lo)
      y = lo;
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic void shift_line(logic signed [SAMPLE_BITS-1:0] s);
    for (int i = LINE_LEN - 1; i > 0; i--)
      fir_line[i] = fir_line[i-1];
    fir_line[0] = s;
  endfunction

  // Works out every filtered sample that one accepted input sample releases.
  function automatic void predict_filtered(audio_beat_t beat);
    int unsigned steps;
    audio_beat_t r;
    steps = beat.last ? HALF_TAPS : 1;
    // The first sample of a block fills the whole line, which clamps the left edge.
    if (block_fill == 0) begin
      for (int i = 0; i < LINE_LEN; i++)
        fir_line[i] = beat.sample;
    end else begin
      shift_line(beat.sample);
    end
    if (block_fill < HALF_TAPS)
      block_fill++;
    // On the last sample the line keeps taking that sample, which clamps the right edge.
    for (int p = 0; p < steps; p++) begin
      if (p > 0)
        shift_line(beat.sample);
      if (block_fill + p >= HALF_TAPS) begin
        r.sample = window_output();
        r.last   = beat.last && (p == steps - 1);
        expected_samples.push_back(r);
      end
    end
    if (beat.last)
      block_fill = 0;
  endfunction

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    audio_beat_t want;
    cycle_count++;
    in_beat  = in_valid && in_ready;
    cfg_beat = cfg_valid && cfg_ready;
    if (!rst_n) begin
      // Synchronous reset: the predictor returns to the pass-through setting.
      for (int i = 0; i < LINE_LEN; i++)
        fir_line[i] = '0;
      for (int i = 0; i < NUM_TAP_REGS; i++)
        tap_words[i] = '0;
      tap_words[REG_TAPS_0_1] = TAPS_0_1_RESET;
      block_fill = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t ns: unexpected filtered sample: expected none, got %0d last %0b",
                     $time, out_sample, out_last);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_sample !== want.sample) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t ns: out_sample mismatch: expected %0d, got %0d",
                       $time, $signed(want.sample), out_sample);
          end
          if (out_last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t ns: out_last mismatch: expected %0b, got %0b",
                       $time, want.last, out_last);
          end
        end
      end
      if (cfg_beat) begin
        cfg_writes++;
        if (cfg_index < NUM_TAP_REGS)
          tap_words[cfg_index] = cfg_data;
      end
      if (in_beat) begin
        samples_taken++;
        predict_filtered('{last: in_last, sample: in_sample});
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles with %0d filtered samples owed",
               $time, cycle_count, expected_samples.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Sample driver: a new beat may only replace the current one once it was accepted.
  always @(negedge clk) begin
    audio_beat_t next_beat;
    if (!in_valid || in_beat) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_valid  <= 1'b1;
        in_sample <= next_beat.sample;
        in_last   <= next_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, or a long hold whenever one has been asked for.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_beat(logic signed [SAMPLE_BITS-1:0] s, logic last);
    pending_beats.push_back('{last: last, sample: s});
    if (last)
      blocks_queued++;
  endtask

  // Most samples are uniform over the full range; some sit on the rails.
  task automatic queue_random_block(int unsigned len);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0)
        s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      else
        s = SAMPLE_BITS'($urandom);
      queue_beat(s, i == len - 1);
    end
  endtask

  // Called right after a falling edge; cfg_valid stays high across back-to-back writes
  // and the caller lowers it after the last one.
  task automatic write_reg(tap_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_beat);
  endtask

  // The sender stays quiet until every owed result is out and the pipeline has emptied.
  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly modest coefficients so that the outputs stay in range, with some full-scale ones.
  function automatic logic [COEF_W-1:0] random_coef();
    if ($urandom_range(3) == 0)
      return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(4095)) - 2048);
  endfunction

  function automatic int unsigned random_block_len();
    case ($urandom_range(9))
      0:       return 1;
      1:       return HALF_TAPS - 1;
      2:       return HALF_TAPS;
      3:       return HALF_TAPS + 1;
      default: return $urandom_range(48, 2);
    endcase
  endfunction

  initial begin
    int unsigned phase_samples;
    int unsigned len;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the sender rarely idle and the receiver mostly stalled.
    tx_idle_pct = 7;
    rx_idle_pct = 77;

    // Reset coefficients pass each sample through at a gain just under one; one-sample blocks at the rails and zero.
    queue_beat(SAMPLE_MAX, 1'b1);
    queue_beat(SAMPLE_MIN, 1'b1);
    queue_beat(16'sd0, 1'b1);
    drain_and_settle();

    // Every coefficient at its largest: the gain of about 31 drives the last result into negative saturation.
    // The write to an index past the register file must not disturb any coefficient.
    for (int r = 0; r < NUM_TAP_REGS; r++)
      write_reg(tap_reg_t'(r), TAPS_ALL_MAX);
    write_reg(REG_OUT_OF_RANGE, '0);
    cfg_valid <= 1'b0;
    queue_beat(SAMPLE_MAX, 1'b0);
    queue_beat(SAMPLE_MIN, 1'b1);
    drain_and_settle();

    // Every coefficient at -1.0, and a block just one sample longer than the fill.
    for (int r = 0; r < NUM_TAP_REGS; r++)
      write_reg(tap_reg_t'(r), TAPS_ALL_MIN);
    cfg_valid <= 1'b0;
    for (int i = 0; i < HALF_TAPS + 1; i++)
      queue_beat((i % 3 == 0) ? SAMPLE_MAX : (i % 3 == 1) ? SAMPLE_MIN : 16'sd0,
                 i == HALF_TAPS);
    drain_and_settle();

    // Random part in three phases, each with fresh coefficients and its own idle pattern.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 77 : 0;
      rx_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 7 : 0;
      for (int r = 0; r < NUM_TAP_REGS; r++)
        write_reg(tap_reg_t'(r), {random_coef(), random_coef()});
      cfg_valid <= 1'b0;
      // In the phase without idles, the receiver holds off for a long stretch while the
      // sender keeps offering, so the block has to back up and stall its input.
      if (ph == 2)
        holds_asked++;
      phase_samples = 0;
      while (phase_samples < PHASE_SAMPLES) begin
        len = random_block_len();
        queue_random_block(len);
        phase_samples += len;
      end
      drain_and_settle();
    end

    $display("Run covered %0d samples in %0d blocks and %0d coefficient writes;",
             samples_taken, blocks_queued, cfg_writes);
    $display("%0d filtered samples checked, %0d errors.", samples_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
